// ===== sv/sgm_pkg.sv =====
// Shared constants, codes and the pipeline control type of the Sobel gradient
// magnitude core. No dependencies; every other file in the project uses it.
package sgm_pkg;

   // Frame limits; the line store holds this many pixels per line.
   localparam int MAX_LINE_LENGTH = 1024;
   localparam int MAX_LINE_COUNT  = 1024;
   localparam int LINE_ADDR_W     = $clog2(MAX_LINE_LENGTH);

   // Field widths.
   localparam int CFG_W       = 11;
   localparam int PIX_W       = 8;
   localparam int CSR_INDEX_W = 2;

   // Window geometry: five rows, four of them held in line banks.
   localparam int WIN    = 5;
   localparam int WIN3   = 3;
   localparam int BANKS  = WIN - 1;
   localparam int BANK_W = $clog2(BANKS);

   // Datapath widths.
   localparam int A5_W   = 11;  // 2p0+p1-p3-2p4, signed
   localparam int B5_W   = 11;  // p0+p1+2p2+p3+p4
   localparam int A3_W   = 9;   // p2-p4, signed
   localparam int B3_W   = 10;  // p2+2p3+p4
   localparam int GRAD_W = 14;  // signed gradient
   localparam int ABS_W  = GRAD_W - 1;
   localparam int SQ_W   = 2 * ABS_W;
   localparam int SUM_W  = 2 * PIX_W;
   localparam int SQRT_STEPS = PIX_W;

   // Register reset values and the smallest frame dimension.
   localparam logic [CFG_W-1:0] MIN_DIM         = 11'd5;
   localparam logic [CFG_W-1:0] LINE_LENGTH_RST = 11'd640;
   localparam logic [CFG_W-1:0] LINE_COUNT_RST  = 11'd480;

   // Kernel mode and item kind codes.
   localparam logic MODE_3X3   = 1'b0;
   localparam logic MODE_5X5   = 1'b1;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINE_LENGTH = 2'd0,
      REG_LINE_COUNT  = 2'd1,
      REG_KERNEL_MODE = 2'd2
   } reg_index_type;

   // Control that travels with each item through the pipeline.
   typedef struct packed {
      logic valid;
      logic pixel;
      logic emit;
      logic border;
      logic last;
      logic mode;
   } ctl_type;

endpackage

// ===== sv/sgm_req_if.sv =====
// Input channel of the Sobel core: pixel or drain items with valid/ready.
// Depends on sgm_pkg for the pixel width.
interface sgm_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [sgm_pkg::PIX_W-1:0] pixel_value;

   modport source (output valid, kind, pixel_value, input ready);
   modport sink   (input valid, kind, pixel_value, output ready);
endinterface

// ===== sv/sgm_rsp_if.sv =====
// Result channel of the Sobel core: magnitude and end-of-frame flag.
// Depends on sgm_pkg for the pixel width.
interface sgm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sgm_pkg::PIX_W-1:0] magnitude;
   logic                      frame_last;

   modport source (output valid, magnitude, frame_last, input ready);
   modport sink   (input valid, magnitude, frame_last, output ready);
endinterface

// ===== sv/sgm_csr_if.sv =====
// Register write channel of the Sobel core: index and data with valid/ready.
// Depends on sgm_pkg for the index and data widths.
interface sgm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sgm_pkg::CSR_INDEX_W-1:0] index;
   logic [sgm_pkg::CFG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sobel_gradient_magnitude_core.sv =====
// Streaming Sobel gradient magnitude: one item (pixel or drain) is taken per
// clock while the pipeline advances. After an item is taken, its result passes
// through one stage for the line bank read, one for the window shift, one
// for the gradients, one for the squares, one for the clamped sum and eight for
// the root, one bit each. The whole pipeline moves together and holds only while
// the output register has a result that is not taken, so ready follows the
// result side in the same cycle. The line banks need no clearing after reset.
// Depends on sgm_pkg, the three channel interfaces and the sgm_* stage modules.
module sobel_gradient_magnitude_core (
   input  logic       clock,
   input  logic       reset,
   sgm_req_if.sink    req_if,
   sgm_rsp_if.source  rsp_if,
   sgm_csr_if.sink    csr_if
);

   logic                                        adv, accept;
   logic [sgm_pkg::LINE_ADDR_W-1:0]             rd_addr;
   logic                                        wr_en;
   logic [sgm_pkg::BANK_W-1:0]                  wr_bank;
   sgm_pkg::ctl_type                            s1_ctl, s3_ctl;
   logic [sgm_pkg::WIN-1:0][sgm_pkg::PIX_W-1:0] column;
   logic [sgm_pkg::ABS_W-1:0]                   h_abs, v_abs;

   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;
   assign accept       = req_if.valid && adv;
   assign csr_if.ready = 1'b1;

   sgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .accept    (accept),
      .kind      (req_if.kind),
      .csr_write (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_bank   (wr_bank),
      .s1_ctl    (s1_ctl)
   );

   sgm_line_store u_line_store (
      .clock       (clock),
      .adv         (adv),
      .rd_addr     (rd_addr),
      .wr_en       (wr_en),
      .wr_bank     (wr_bank),
      .pixel_value (req_if.pixel_value),
      .column      (column)
   );

   sgm_window u_window (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .s1_ctl (s1_ctl),
      .column (column),
      .s3_ctl (s3_ctl),
      .h_abs  (h_abs),
      .v_abs  (v_abs)
   );

   sgm_magnitude u_magnitude (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .s3_ctl        (s3_ctl),
      .h_abs         (h_abs),
      .v_abs         (v_abs),
      .out_valid     (rsp_if.valid),
      .out_magnitude (rsp_if.magnitude),
      .out_last      (rsp_if.frame_last)
   );

endmodule

// ===== sv/sgm_ctrl.sv =====
// Front stage of the Sobel core: configuration registers, input and output
// position counters, frame tail tracking and line store addressing. Uses sgm_pkg.
module sgm_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              accept,
   input  logic                              kind,
   input  logic                              csr_write,
   input  logic [sgm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sgm_pkg::CFG_W-1:0]         csr_data,
   output logic [sgm_pkg::LINE_ADDR_W-1:0]   rd_addr,
   output logic                              wr_en,
   output logic [sgm_pkg::BANK_W-1:0]        wr_bank,
   output sgm_pkg::ctl_type                  s1_ctl
);

   logic [sgm_pkg::CFG_W-1:0] len_ff, cnt_ff;
   logic                      mode_ff;
   logic [sgm_pkg::CFG_W-1:0] in_line_ff, in_line_in, in_col_ff, in_col_in;
   logic [sgm_pkg::CFG_W-1:0] out_line_ff, out_line_in, out_col_ff, out_col_in;
   logic                      tail_ff, tail_in;
   sgm_pkg::ctl_type          s1_ctl_ff, s1_ctl_in;

   logic [sgm_pkg::CFG_W-1:0] len_eff, cnt_eff, rad;
   logic                      is_pixel, in_ready, emit, border, last;
   logic                      out_col_end, out_line_end, in_col_end, in_line_end;

   // Effective frame size saturates to the supported range.
   always_comb begin
      if (len_ff < sgm_pkg::MIN_DIM) begin
         len_eff = sgm_pkg::MIN_DIM;
      end else if (32'(len_ff) > sgm_pkg::MAX_LINE_LENGTH) begin
         len_eff = sgm_pkg::CFG_W'(sgm_pkg::MAX_LINE_LENGTH);
      end else begin
         len_eff = len_ff;
      end
      if (cnt_ff < sgm_pkg::MIN_DIM) begin
         cnt_eff = sgm_pkg::MIN_DIM;
      end else if (32'(cnt_ff) > sgm_pkg::MAX_LINE_COUNT) begin
         cnt_eff = sgm_pkg::CFG_W'(sgm_pkg::MAX_LINE_COUNT);
      end else begin
         cnt_eff = cnt_ff;
      end
   end

   assign rad = (mode_ff == sgm_pkg::MODE_5X5) ? sgm_pkg::CFG_W'(2) : sgm_pkg::CFG_W'(1);

   assign is_pixel = (kind != sgm_pkg::KIND_DRAIN);
   assign in_ready = (in_line_ff > rad) || ((in_line_ff == rad) && (in_col_ff >= rad));
   // A pixel produces a result once the window is primed; while the previous
   // frame still owes results, every item pays one of them out.
   assign emit     = tail_ff || (is_pixel && in_ready);

   assign border = (out_line_ff < rad) || (out_line_ff >= cnt_eff - rad) ||
                   (out_col_ff < rad) || (out_col_ff >= len_eff - rad);
   assign last   = (out_line_ff >= cnt_eff - sgm_pkg::CFG_W'(1)) &&
                   (out_col_ff >= len_eff - sgm_pkg::CFG_W'(1));

   assign out_col_end  = ({1'b0, out_col_ff} + (sgm_pkg::CFG_W+1)'(1)) >= {1'b0, len_eff};
   assign out_line_end = ({1'b0, out_line_ff} + (sgm_pkg::CFG_W+1)'(1)) >= {1'b0, cnt_eff};
   assign in_col_end   = ({1'b0, in_col_ff} + (sgm_pkg::CFG_W+1)'(1)) >= {1'b0, len_eff};
   assign in_line_end  = ({1'b0, in_line_ff} + (sgm_pkg::CFG_W+1)'(1)) >= {1'b0, cnt_eff};

   always_comb begin
      in_line_in  = in_line_ff;
      in_col_in   = in_col_ff;
      out_line_in = out_line_ff;
      out_col_in  = out_col_ff;
      tail_in     = tail_ff;
      if (accept) begin
         if (emit) begin
            if (out_col_end) begin
               out_col_in = '0;
               if (out_line_end) begin
                  out_line_in = '0;
                  tail_in     = 1'b0;
               end else begin
                  out_line_in = out_line_ff + sgm_pkg::CFG_W'(1);
               end
            end else begin
               out_col_in = out_col_ff + sgm_pkg::CFG_W'(1);
            end
         end
         if (is_pixel) begin
            if (in_col_end) begin
               in_col_in = '0;
               if (in_line_end) begin
                  in_line_in = '0;
                  tail_in    = 1'b1;
               end else begin
                  in_line_in = in_line_ff + sgm_pkg::CFG_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + sgm_pkg::CFG_W'(1);
            end
         end
      end
   end

   always_comb begin
      s1_ctl_in.valid  = accept;
      s1_ctl_in.pixel  = is_pixel;
      s1_ctl_in.emit   = emit;
      s1_ctl_in.border = border;
      s1_ctl_in.last   = last;
      s1_ctl_in.mode   = mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= sgm_pkg::LINE_LENGTH_RST;
         cnt_ff      <= sgm_pkg::LINE_COUNT_RST;
         mode_ff     <= sgm_pkg::MODE_5X5;
         in_line_ff  <= '0;
         in_col_ff   <= '0;
         out_line_ff <= '0;
         out_col_ff  <= '0;
         tail_ff     <= 1'b0;
         s1_ctl_ff   <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               sgm_pkg::REG_LINE_LENGTH: len_ff  <= csr_data;
               sgm_pkg::REG_LINE_COUNT:  cnt_ff  <= csr_data;
               sgm_pkg::REG_KERNEL_MODE: mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         in_line_ff  <= in_line_in;
         in_col_ff   <= in_col_in;
         out_line_ff <= out_line_in;
         out_col_ff  <= out_col_in;
         tail_ff     <= tail_in;
         if (adv) begin
            s1_ctl_ff <= s1_ctl_in;
         end
      end
   end

   assign rd_addr = sgm_pkg::LINE_ADDR_W'(in_col_ff);
   assign wr_en   = accept && is_pixel;
   assign wr_bank = in_line_ff[sgm_pkg::BANK_W-1:0];
   assign s1_ctl  = s1_ctl_ff;

endmodule

// ===== sv/sgm_line_store.sv =====
// Four line banks of the Sobel core, read first then written at the same column,
// and the rotation that lines the banks up as window rows. Uses sgm_pkg.
module sgm_line_store (
   input  logic                                          clock,
   input  logic                                          adv,
   input  logic [sgm_pkg::LINE_ADDR_W-1:0]               rd_addr,
   input  logic                                          wr_en,
   input  logic [sgm_pkg::BANK_W-1:0]                    wr_bank,
   input  logic [sgm_pkg::PIX_W-1:0]                     pixel_value,
   output logic [sgm_pkg::WIN-1:0][sgm_pkg::PIX_W-1:0]   column
);

   logic [sgm_pkg::PIX_W-1:0] mem [sgm_pkg::BANKS][sgm_pkg::MAX_LINE_LENGTH];
   logic [sgm_pkg::PIX_W-1:0] rd_ff [sgm_pkg::BANKS];
   logic [sgm_pkg::PIX_W-1:0] pix_ff;
   logic [sgm_pkg::BANK_W-1:0] bank_ff;

   // Each bank is written at one column and read at the same column; the read
   // returns the pixel from four lines back before it is overwritten.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int b = 0; b < sgm_pkg::BANKS; b++) begin
            if (wr_en && (wr_bank == sgm_pkg::BANK_W'(b))) begin
               mem[b][rd_addr] <= pixel_value;
            end
            rd_ff[b] <= mem[b][rd_addr];
         end
         pix_ff  <= pixel_value;
         bank_ff <= wr_bank;
      end
   end

   // Row k of the new window column comes from bank (line + k) mod 4, the
   // oldest line first; the bottom row is the incoming pixel.
   always_comb begin
      for (int k = 0; k < sgm_pkg::BANKS; k++) begin
         column[k] = rd_ff[bank_ff + sgm_pkg::BANK_W'(k)];
      end
      column[sgm_pkg::WIN-1] = pix_ff;
   end

endmodule

// ===== sv/sgm_window.sv =====
// Window of the Sobel core kept as per-column kernel sums, and the horizontal
// and vertical gradient stage that yields their absolute values. Uses sgm_pkg.
module sgm_window (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         adv,
   input  sgm_pkg::ctl_type                             s1_ctl,
   input  logic [sgm_pkg::WIN-1:0][sgm_pkg::PIX_W-1:0]  column,
   output sgm_pkg::ctl_type                             s3_ctl,
   output logic [sgm_pkg::ABS_W-1:0]                    h_abs,
   output logic [sgm_pkg::ABS_W-1:0]                    v_abs
);

   // Both kernels are separable, so a column enters the window as its
   // vertical derivative and its vertical smoothing sum.
   logic signed [sgm_pkg::A5_W-1:0] a5_in;
   logic        [sgm_pkg::B5_W-1:0] b5_in;
   logic signed [sgm_pkg::A3_W-1:0] a3_in;
   logic        [sgm_pkg::B3_W-1:0] b3_in;

   logic signed [sgm_pkg::A5_W-1:0] a5_ff [sgm_pkg::WIN];
   logic        [sgm_pkg::B5_W-1:0] b5_ff [sgm_pkg::WIN];
   logic signed [sgm_pkg::A3_W-1:0] a3_ff [sgm_pkg::WIN3];
   logic        [sgm_pkg::B3_W-1:0] b3_ff [sgm_pkg::WIN3];

   sgm_pkg::ctl_type s2_ctl_ff, s3_ctl_ff, s3_ctl_in;

   logic signed [sgm_pkg::GRAD_W-1:0] h5, v5, h3, v3, h_sel, v_sel;
   logic [sgm_pkg::ABS_W-1:0]         h_abs_ff, h_abs_in, v_abs_ff, v_abs_in;

   always_comb begin
      a5_in = (signed'(sgm_pkg::A5_W'(column[0])) <<< 1)
            + signed'(sgm_pkg::A5_W'(column[1]))
            - signed'(sgm_pkg::A5_W'(column[3]))
            - (signed'(sgm_pkg::A5_W'(column[4])) <<< 1);
      b5_in = sgm_pkg::B5_W'(column[0]) + sgm_pkg::B5_W'(column[1])
            + (sgm_pkg::B5_W'(column[2]) << 1)
            + sgm_pkg::B5_W'(column[3]) + sgm_pkg::B5_W'(column[4]);
      a3_in = signed'(sgm_pkg::A3_W'(column[2])) - signed'(sgm_pkg::A3_W'(column[4]));
      b3_in = sgm_pkg::B3_W'(column[2]) + (sgm_pkg::B3_W'(column[3]) << 1)
            + sgm_pkg::B3_W'(column[4]);
   end

   // Window shift on every pixel transfer out of the first stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < sgm_pkg::WIN; c++) begin
            a5_ff[c] <= '0;
            b5_ff[c] <= '0;
         end
         for (int c = 0; c < sgm_pkg::WIN3; c++) begin
            a3_ff[c] <= '0;
            b3_ff[c] <= '0;
         end
      end else if (adv && s1_ctl.valid && s1_ctl.pixel) begin
         for (int c = 0; c < sgm_pkg::WIN - 1; c++) begin
            a5_ff[c] <= a5_ff[c+1];
            b5_ff[c] <= b5_ff[c+1];
         end
         a5_ff[sgm_pkg::WIN-1] <= a5_in;
         b5_ff[sgm_pkg::WIN-1] <= b5_in;
         for (int c = 0; c < sgm_pkg::WIN3 - 1; c++) begin
            a3_ff[c] <= a3_ff[c+1];
            b3_ff[c] <= b3_ff[c+1];
         end
         a3_ff[sgm_pkg::WIN3-1] <= a3_in;
         b3_ff[sgm_pkg::WIN3-1] <= b3_in;
      end
   end

   // The item in the second stage sees the window right after its own shift.
   always_comb begin
      h5 = sgm_pkg::GRAD_W'(a5_ff[0]) + sgm_pkg::GRAD_W'(a5_ff[1])
         + (sgm_pkg::GRAD_W'(a5_ff[2]) <<< 1)
         + sgm_pkg::GRAD_W'(a5_ff[3]) + sgm_pkg::GRAD_W'(a5_ff[4]);
      v5 = (signed'(sgm_pkg::GRAD_W'(b5_ff[0])) <<< 1)
         + signed'(sgm_pkg::GRAD_W'(b5_ff[1]))
         - signed'(sgm_pkg::GRAD_W'(b5_ff[3]))
         - (signed'(sgm_pkg::GRAD_W'(b5_ff[4])) <<< 1);
      h3 = sgm_pkg::GRAD_W'(a3_ff[0]) + (sgm_pkg::GRAD_W'(a3_ff[1]) <<< 1)
         + sgm_pkg::GRAD_W'(a3_ff[2]);
      v3 = signed'(sgm_pkg::GRAD_W'(b3_ff[2])) - signed'(sgm_pkg::GRAD_W'(b3_ff[0]));
      if (s2_ctl_ff.mode == sgm_pkg::MODE_5X5) begin
         h_sel = h5;
         v_sel = v5;
      end else begin
         h_sel = h3;
         v_sel = v3;
      end
      h_abs_in = h_sel[sgm_pkg::GRAD_W-1] ? sgm_pkg::ABS_W'(-h_sel) : sgm_pkg::ABS_W'(h_sel);
      v_abs_in = v_sel[sgm_pkg::GRAD_W-1] ? sgm_pkg::ABS_W'(-v_sel) : sgm_pkg::ABS_W'(v_sel);
   end

   always_comb begin
      s3_ctl_in       = s2_ctl_ff;
      // Past this point only items that produce a result stay valid.
      s3_ctl_in.valid = s2_ctl_ff.valid && s2_ctl_ff.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (adv) begin
         s2_ctl_ff <= s1_ctl;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_abs_ff <= h_abs_in;
         v_abs_ff <= v_abs_in;
      end
   end

   assign s3_ctl = s3_ctl_ff;
   assign h_abs  = h_abs_ff;
   assign v_abs  = v_abs_ff;

endmodule

// ===== sv/sgm_magnitude.sv =====
// Magnitude back end of the Sobel core: squares, saturating sum and a
// bit-per-stage rounded square root whose last stage is the output register.
// Uses sgm_pkg.
module sgm_magnitude (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  sgm_pkg::ctl_type              s3_ctl,
   input  logic [sgm_pkg::ABS_W-1:0]     h_abs,
   input  logic [sgm_pkg::ABS_W-1:0]     v_abs,
   output logic                          out_valid,
   output logic [sgm_pkg::PIX_W-1:0]     out_magnitude,
   output logic                          out_last
);

   sgm_pkg::ctl_type              s4_ctl_ff, s5_ctl_ff;
   sgm_pkg::ctl_type              st_ctl_ff [sgm_pkg::SQRT_STEPS];
   logic [sgm_pkg::SQ_W-1:0]      hh_in, vv_in, hh_ff, vv_ff;
   logic [sgm_pkg::SQ_W:0]        sum_full;
   logic [sgm_pkg::SUM_W-1:0]     sum_in, sum_ff;
   logic [sgm_pkg::SUM_W-1:0]     st_s_ff [sgm_pkg::SQRT_STEPS];
   logic [sgm_pkg::PIX_W-1:0]     st_n_ff [sgm_pkg::SQRT_STEPS];
   logic [sgm_pkg::PIX_W-1:0]     st_n_in [sgm_pkg::SQRT_STEPS];

   assign hh_in = h_abs * h_abs;
   assign vv_in = v_abs * v_abs;

   // Anything at or above 2^16 already rounds to full scale, so the sum is
   // clamped there. A border pixel enters the root as zero and leaves as zero.
   assign sum_full = {1'b0, hh_ff} + {1'b0, vv_ff};
   always_comb begin
      if (s4_ctl_ff.border) begin
         sum_in = '0;
      end else if (sum_full[sgm_pkg::SQ_W:sgm_pkg::SUM_W] != '0) begin
         sum_in = '1;
      end else begin
         sum_in = sum_full[sgm_pkg::SUM_W-1:0];
      end
   end

   // Each step keeps its trial bit when t*(t-1) < S: the largest such n is
   // the square root rounded half up.
   always_comb begin
      logic [sgm_pkg::PIX_W-1:0] n_prev;
      logic [sgm_pkg::SUM_W-1:0] s_prev;
      logic [sgm_pkg::PIX_W-1:0] t;
      logic [sgm_pkg::SUM_W-1:0] prod;
      for (int k = 0; k < sgm_pkg::SQRT_STEPS; k++) begin
         if (k == 0) begin
            n_prev = '0;
            s_prev = sum_ff;
         end else begin
            n_prev = st_n_ff[k-1];
            s_prev = st_s_ff[k-1];
         end
         t    = n_prev | (sgm_pkg::PIX_W'(1) << (sgm_pkg::SQRT_STEPS - 1 - k));
         prod = sgm_pkg::SUM_W'(t) * sgm_pkg::SUM_W'(t - sgm_pkg::PIX_W'(1));
         st_n_in[k] = (prod < s_prev) ? t : n_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
         for (int k = 0; k < sgm_pkg::SQRT_STEPS; k++) begin
            st_ctl_ff[k] <= '0;
         end
      end else if (adv) begin
         s4_ctl_ff    <= s3_ctl;
         s5_ctl_ff    <= s4_ctl_ff;
         st_ctl_ff[0] <= s5_ctl_ff;
         for (int k = 1; k < sgm_pkg::SQRT_STEPS; k++) begin
            st_ctl_ff[k] <= st_ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hh_ff      <= hh_in;
         vv_ff      <= vv_in;
         sum_ff     <= sum_in;
         st_s_ff[0] <= sum_ff;
         st_n_ff[0] <= st_n_in[0];
         for (int k = 1; k < sgm_pkg::SQRT_STEPS; k++) begin
            st_s_ff[k] <= st_s_ff[k-1];
            st_n_ff[k] <= st_n_in[k];
         end
      end
   end

   assign out_valid     = st_ctl_ff[sgm_pkg::SQRT_STEPS-1].valid;
   assign out_last      = st_ctl_ff[sgm_pkg::SQRT_STEPS-1].last;
   assign out_magnitude = st_n_ff[sgm_pkg::SQRT_STEPS-1];

endmodule
